### hw/rtl/gcfs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcfs_pkg: shared types and constants of the cell face sweep classifier
// Widths, face codes, register map, geometry and task words, helper functions.
// ----------------------------------------------------------------------------
package gcfs_pkg;

	// largest box edge in cells
	localparam int MAX_CELLS_PER_AXIS = 256;

	// fixed field widths
	localparam int SIZE_W     = 9;
	localparam int IDX_W      = 24;
	localparam int OMEGA_W    = 16;
	localparam int FACE_W     = 3;
	localparam int FACE_COUNT = 6;
	localparam int DATA_W     = 32;
	localparam int PADDR_W    = 4;
	localparam int REG_SEL_W  = PADDR_W - 2;

	// derived from the box edge limit
	localparam int AXIS_W  = $clog2(MAX_CELLS_PER_AXIS + 1);
	localparam int COORD_W = $clog2(MAX_CELLS_PER_AXIS);
	localparam int PLANE_W = 2 * COORD_W + 1;
	localparam int TOTAL_W = 3 * COORD_W + 1;
	localparam int DIV_W   = ((IDX_W > PLANE_W + COORD_W) ? IDX_W : PLANE_W + COORD_W) + 1;
	localparam int CMP_W   = (IDX_W > TOTAL_W) ? IDX_W : TOTAL_W;

	// size registers after reset
	localparam int RESET_SIZE = 4;

	// task queue
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	// register map (word index)
	localparam logic [REG_SEL_W-1:0] REG_CELLS_X = REG_SEL_W'(0);
	localparam logic [REG_SEL_W-1:0] REG_CELLS_Y = REG_SEL_W'(1);
	localparam logic [REG_SEL_W-1:0] REG_CELLS_Z = REG_SEL_W'(2);

	// faces in sweep order
	typedef enum logic [FACE_W-1:0] {
		FACE_NEG_Y = 3'd0,
		FACE_POS_X = 3'd1,
		FACE_POS_Y = 3'd2,
		FACE_NEG_X = 3'd3,
		FACE_NEG_Z = 3'd4,
		FACE_POS_Z = 3'd5
	} face_t;

	// box geometry seen by front and back
	typedef struct packed {
		logic [AXIS_W-1:0]  cx;
		logic [AXIS_W-1:0]  cy;
		logic [AXIS_W-1:0]  cz;
		logic [PLANE_W-1:0] plane;
		logic [TOTAL_W-1:0] total;
	} geom_t;

	// classified cell, one queue word
	typedef struct packed {
		logic [IDX_W-1:0]      idx;
		logic [FACE_COUNT-1:0] inc;
		logic [FACE_COUNT-1:0] bnd;
		logic                  rerr;
	} task_t;

	// zero reads as one, above the limit reads as the limit
	function automatic logic [AXIS_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
		logic [AXIS_W-1:0] r;
		if (v == '0) begin
			r = AXIS_W'(1);
		end else if (32'(v) > 32'(MAX_CELLS_PER_AXIS)) begin
			r = AXIS_W'(MAX_CELLS_PER_AXIS);
		end else begin
			r = AXIS_W'(v);
		end
		return r;
	endfunction

	function automatic face_t opposite_face(input face_t f);
		face_t r;
		unique case (f)
			FACE_NEG_Y: r = FACE_POS_Y;
			FACE_POS_X: r = FACE_NEG_X;
			FACE_POS_Y: r = FACE_NEG_Y;
			FACE_NEG_X: r = FACE_POS_X;
			FACE_NEG_Z: r = FACE_POS_Z;
			FACE_POS_Z: r = FACE_NEG_Z;
			default:    r = FACE_NEG_Y;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

### hw/rtl/gcfs_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcfs_ifs: channel interfaces of the cell face sweep classifier
// Cell word channel in, face result word channel out, valid/ready handshake.
// ----------------------------------------------------------------------------
interface gcfs_item_if;
	import gcfs_pkg::*;
	logic                       valid;
	logic                       ready;
	logic [IDX_W-1:0]           cell_index;
	logic signed [OMEGA_W-1:0]  omega_x;
	logic signed [OMEGA_W-1:0]  omega_y;
	logic signed [OMEGA_W-1:0]  omega_z;

	modport source (output valid, cell_index, omega_x, omega_y, omega_z, input ready);
	modport sink (input valid, cell_index, omega_x, omega_y, omega_z, output ready);
endinterface

interface gcfs_face_if;
	import gcfs_pkg::*;
	logic              valid;
	logic              ready;
	logic [FACE_W-1:0] face_number;
	logic              is_incoming;
	logic [IDX_W-1:0]  neighbor_cell;
	logic [FACE_W-1:0] neighbor_face;
	logic              crosses_cellset;
	logic              range_error;
	logic              last_face;

	modport source (output valid, face_number, is_incoming, neighbor_cell, neighbor_face,
		crosses_cellset, range_error, last_face, input ready);
	modport sink (input valid, face_number, is_incoming, neighbor_cell, neighbor_face,
		crosses_cellset, range_error, last_face, output ready);
endinterface
`default_nettype wire

### hw/rtl/gcfs_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcfs_cfg: box size registers
// APB-style register file; clamps the sizes and registers plane and box cell
// counts for the front and back parts.
// ----------------------------------------------------------------------------
module gcfs_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [gcfs_pkg::PADDR_W-1:0]   paddr,
	input  logic [gcfs_pkg::DATA_W-1:0]    pwdata,
	output logic [gcfs_pkg::DATA_W-1:0]    prdata,
	output logic                           pready,
	output gcfs_pkg::geom_t                geom
);
	import gcfs_pkg::*;

	logic [SIZE_W-1:0]    cells_x_q, cells_y_q, cells_z_q;
	logic [AXIS_W-1:0]    cx_c, cy_c, cz_c;
	logic [PLANE_W-1:0]   plane_q;
	logic [TOTAL_W-1:0]   total_q;
	logic                 wr_en;
	logic [REG_SEL_W-1:0] sel;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign sel    = paddr[PADDR_W-1:2];

	// register writes; unknown addresses are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cells_x_q <= SIZE_W'(RESET_SIZE);
			cells_y_q <= SIZE_W'(RESET_SIZE);
			cells_z_q <= SIZE_W'(RESET_SIZE);
		end else if (wr_en) begin
			unique case (sel)
				REG_CELLS_X: cells_x_q <= pwdata[SIZE_W-1:0];
				REG_CELLS_Y: cells_y_q <= pwdata[SIZE_W-1:0];
				REG_CELLS_Z: cells_z_q <= pwdata[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (sel)
			REG_CELLS_X: prdata = DATA_W'(cells_x_q);
			REG_CELLS_Y: prdata = DATA_W'(cells_y_q);
			REG_CELLS_Z: prdata = DATA_W'(cells_z_q);
			default:     prdata = '0;
		endcase
	end

	assign cx_c = clamp_size(cells_x_q);
	assign cy_c = clamp_size(cells_y_q);
	assign cz_c = clamp_size(cells_z_q);

	// plane and box cell counts, one multiply per register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q <= PLANE_W'(RESET_SIZE * RESET_SIZE);
			total_q <= TOTAL_W'(RESET_SIZE * RESET_SIZE * RESET_SIZE);
		end else begin
			plane_q <= PLANE_W'(cx_c) * PLANE_W'(cy_c);
			total_q <= TOTAL_W'(plane_q) * TOTAL_W'(cz_c);
		end
	end

	assign geom.cx    = cx_c;
	assign geom.cy    = cy_c;
	assign geom.cz    = cz_c;
	assign geom.plane = plane_q;
	assign geom.total = total_q;

endmodule
`default_nettype wire

### hw/rtl/gcfs_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcfs_front: cell word intake and classification
// Restoring divider pipeline, one quotient bit per stage: z from the index by
// the plane size, then y and x from the remainder by the row size. The last
// stage adds boundary and range flags to the incoming ones and pushes a task word.
// ----------------------------------------------------------------------------
module gcfs_front (
	input  logic             clk,
	input  logic             arst_n,
	gcfs_item_if.sink        cells,
	input  gcfs_pkg::geom_t  geom,
	output logic             push,
	output gcfs_pkg::task_t  push_task,
	input  logic             q_ready
);
	import gcfs_pkg::*;

	localparam int NST = 2 * COORD_W;

	typedef struct packed {
		logic [IDX_W-1:0]      idx;
		logic [IDX_W-1:0]      rem;
		logic [COORD_W-1:0]    z;
		logic [COORD_W-1:0]    y;
		logic [FACE_COUNT-1:0] inc;
	} stage_t;

	logic   pipe_vld_s [0:NST];
	stage_t pipe_s     [0:NST];
	stage_t step_d     [1:NST];
	stage_t entry;
	logic   adv;
	logic   pos_x, neg_x, pos_y, neg_y, pos_z, neg_z;

	// whole pipe moves unless the last stage is blocked by the queue
	assign adv         = !pipe_vld_s[NST] || q_ready;
	assign cells.ready = adv;

	// direction signs; zero counts as neither
	assign neg_x = cells.omega_x[OMEGA_W-1];
	assign neg_y = cells.omega_y[OMEGA_W-1];
	assign neg_z = cells.omega_z[OMEGA_W-1];
	assign pos_x = !neg_x && (cells.omega_x != '0);
	assign pos_y = !neg_y && (cells.omega_y != '0);
	assign pos_z = !neg_z && (cells.omega_z != '0);

	always_comb begin
		entry.idx             = cells.cell_index;
		entry.rem             = cells.cell_index;
		entry.z               = '0;
		entry.y               = '0;
		entry.inc             = '0;
		entry.inc[FACE_NEG_Y] = pos_y;
		entry.inc[FACE_POS_X] = neg_x;
		entry.inc[FACE_POS_Y] = neg_y;
		entry.inc[FACE_NEG_X] = pos_x;
		entry.inc[FACE_NEG_Z] = pos_z;
		entry.inc[FACE_POS_Z] = neg_z;
	end

	// one compare/subtract per stage, independent across stages
	always_comb begin
		int                 b;
		logic [DIV_W-1:0]   dv;
		logic               ge;
		for (int k = 1; k <= NST; k++) begin
			step_d[k] = pipe_s[k-1];
			if (k <= COORD_W) begin
				b  = COORD_W - k;
				dv = DIV_W'(geom.plane) << b;
			end else begin
				b  = NST - k;
				dv = DIV_W'(geom.cx) << b;
			end
			ge = DIV_W'(pipe_s[k-1].rem) >= dv;
			if (ge) begin
				step_d[k].rem = pipe_s[k-1].rem - IDX_W'(dv);
				if (k <= COORD_W) begin
					step_d[k].z[b] = 1'b1;
				end else begin
					step_d[k].y[b] = 1'b1;
				end
			end
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= NST; k++) begin
				pipe_vld_s[k] <= 1'b0;
			end
		end else if (adv) begin
			pipe_vld_s[0] <= cells.valid;
			for (int k = 1; k <= NST; k++) begin
				pipe_vld_s[k] <= pipe_vld_s[k-1];
			end
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (adv) begin
			if (cells.valid) begin
				pipe_s[0] <= entry;
			end
			for (int k = 1; k <= NST; k++) begin
				pipe_s[k] <= step_d[k];
			end
		end
	end

	// boundary and range classification on the finished coordinates
	always_comb begin
		logic [AXIS_W-1:0]  x;
		logic [AXIS_W-1:0]  y;
		logic [AXIS_W-1:0]  z;
		logic               rerr;
		x    = pipe_s[NST].rem[AXIS_W-1:0];
		y    = AXIS_W'(pipe_s[NST].y);
		z    = AXIS_W'(pipe_s[NST].z);
		rerr = CMP_W'(pipe_s[NST].idx) >= CMP_W'(geom.total);
		push_task.idx             = pipe_s[NST].idx;
		push_task.inc             = pipe_s[NST].inc;
		push_task.rerr            = rerr;
		push_task.bnd             = '0;
		push_task.bnd[FACE_NEG_Y] = rerr || (y == '0);
		push_task.bnd[FACE_POS_X] = rerr || (x == geom.cx - AXIS_W'(1));
		push_task.bnd[FACE_POS_Y] = rerr || (y == geom.cy - AXIS_W'(1));
		push_task.bnd[FACE_NEG_X] = rerr || (x == '0);
		push_task.bnd[FACE_NEG_Z] = rerr || (z == '0);
		push_task.bnd[FACE_POS_Z] = rerr || (z == geom.cz - AXIS_W'(1));
	end

	assign push = pipe_vld_s[NST] && q_ready;

endmodule
`default_nettype wire

### hw/rtl/gcfs_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcfs_fifo: task queue between front and back
// Small register queue; head word is visible while not empty.
// ----------------------------------------------------------------------------
module gcfs_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  gcfs_pkg::task_t  push_task,
	output logic             q_ready,
	output logic             head_vld,
	output gcfs_pkg::task_t  head,
	input  logic             pop
);
	import gcfs_pkg::*;

	task_t              mem_q [0:FIFO_DEPTH-1];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_AW:0]   cnt_q;
	logic               do_push, do_pop;

	assign q_ready  = cnt_q != (FIFO_AW+1)'(FIFO_DEPTH);
	assign head_vld = cnt_q != '0;
	assign head     = mem_q[rd_ptr_q];
	assign do_push  = push && q_ready;
	assign do_pop   = pop && head_vld;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_task;
		end
	end

endmodule
`default_nettype wire

### hw/rtl/gcfs_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcfs_back: face result sequencer
// Walks the six faces of the head task, one per cycle unless the receiver
// stalls, forms the neighbor index with a single adder, loads the output register.
// ----------------------------------------------------------------------------
module gcfs_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_vld,
	input  gcfs_pkg::task_t  head,
	output logic             pop,
	input  gcfs_pkg::geom_t  geom,
	gcfs_face_if.source      faces
);
	import gcfs_pkg::*;

	face_t             face_q;
	logic              out_vld_q;
	face_t             face_num_q;
	logic              inc_q;
	logic [IDX_W-1:0]  cell_q;
	face_t             nface_q;
	logic              bnd_q;
	logic              rerr_q;
	logic              last_q;

	logic              load;
	logic              is_last;
	logic              f_inc, f_bnd;
	logic              sub;
	logic [IDX_W-1:0]  op;
	logic [IDX_W-1:0]  nb;
	logic [IDX_W-1:0]  cell_d;
	face_t             nface_d;

	assign load    = head_vld && (!out_vld_q || faces.ready);
	assign is_last = face_q == FACE_POS_Z;
	assign pop     = load && is_last;
	assign f_inc   = head.inc[face_q];
	assign f_bnd   = head.bnd[face_q];

	// neighbor offset for the current face
	always_comb begin
		unique case (face_q)
			FACE_NEG_Y: begin sub = 1'b1; op = IDX_W'(geom.cx);    end
			FACE_POS_X: begin sub = 1'b0; op = IDX_W'(1);          end
			FACE_POS_Y: begin sub = 1'b0; op = IDX_W'(geom.cx);    end
			FACE_NEG_X: begin sub = 1'b1; op = IDX_W'(1);          end
			FACE_NEG_Z: begin sub = 1'b1; op = IDX_W'(geom.plane); end
			FACE_POS_Z: begin sub = 1'b0; op = IDX_W'(geom.plane); end
			default:    begin sub = 1'b0; op = '0;                 end
		endcase
	end

	assign nb = sub ? head.idx - op : head.idx + op;

	// incoming gives zeros, boundary gives own cell and face
	always_comb begin
		if (f_inc) begin
			cell_d  = '0;
			nface_d = FACE_NEG_Y;
		end else if (f_bnd) begin
			cell_d  = head.idx;
			nface_d = face_q;
		end else begin
			cell_d  = nb;
			nface_d = opposite_face(face_q);
		end
	end

	// face counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			face_q    <= FACE_NEG_Y;
			out_vld_q <= 1'b0;
		end else begin
			if (load) begin
				face_q    <= is_last ? FACE_NEG_Y : face_t'(face_q + 1'b1);
				out_vld_q <= 1'b1;
			end else if (faces.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// output word
	always_ff @(posedge clk) begin
		if (load) begin
			face_num_q <= face_q;
			inc_q      <= f_inc;
			cell_q     <= cell_d;
			nface_q    <= nface_d;
			bnd_q      <= f_bnd;
			rerr_q     <= head.rerr;
			last_q     <= is_last;
		end
	end

	assign faces.valid           = out_vld_q;
	assign faces.face_number     = face_num_q;
	assign faces.is_incoming     = inc_q;
	assign faces.neighbor_cell   = cell_q;
	assign faces.neighbor_face   = nface_q;
	assign faces.crosses_cellset = bnd_q;
	assign faces.range_error     = rerr_q;
	assign faces.last_face       = last_q;

endmodule
`default_nettype wire

### hw/rtl/grid_cell_face_sweep_classifier.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grid_cell_face_sweep_classifier: six face results per cell of a box
// Channels: cells (sink) takes a cell index and a direction; faces (source)
// gives six words per cell in the order -y, +x, +y, -x, -z, +z, the sixth
// one with last_face set. Box sizes sit in three APB registers at 0x0, 0x4
// and 0x8; write them only while no cell is in flight.
// Path: a cell word passes the entry register, 16 divider stages, the queue
// and the output register before its first face word is valid; the
// others follow one per cycle while the receiver keeps ready high.
// The face sequencer sets the cell rate: six words per cell, one per cycle
// while ready is high, on the single result channel. The front pipe takes a
// cell per cycle until its stages and the 4-deep task queue are full.
// Reset: sizes go to 4, all pipe, queue and output valids clear at once.
// Receiver stall: the output word holds; the sequencer, then the queue,
// then the divider pipe fill and cells.ready drops.
// ----------------------------------------------------------------------------
module grid_cell_face_sweep_classifier (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [gcfs_pkg::PADDR_W-1:0]   paddr,
	input  logic [gcfs_pkg::DATA_W-1:0]    pwdata,
	output logic [gcfs_pkg::DATA_W-1:0]    prdata,
	output logic                           pready,
	gcfs_item_if.sink                      cells,
	gcfs_face_if.source                    faces
);
	import gcfs_pkg::*;

	geom_t geom;
	logic  push, q_ready, head_vld, pop;
	task_t push_task, head;

	// size registers
	gcfs_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.geom    (geom)
	);

	// split and classify
	gcfs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cells     (cells),
		.geom      (geom),
		.push      (push),
		.push_task (push_task),
		.q_ready   (q_ready)
	);

	// task queue
	gcfs_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_task (push_task),
		.q_ready   (q_ready),
		.head_vld  (head_vld),
		.head      (head),
		.pop       (pop)
	);

	// face sequencer
	gcfs_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head_vld (head_vld),
		.head     (head),
		.pop      (pop),
		.geom     (geom),
		.faces    (faces)
	);

	// the closing word of a cell is always the +z face
	a_last_is_pos_z: assert property (@(posedge clk) disable iff (!arst_n)
		faces.valid && faces.last_face |-> faces.face_number == FACE_POS_Z)
		else $error("last face word is not the +z face");

	// incoming faces carry no neighbor
	a_incoming_zero: assert property (@(posedge clk) disable iff (!arst_n)
		faces.valid && faces.is_incoming |->
			faces.neighbor_cell == '0 && faces.neighbor_face == FACE_NEG_Y)
		else $error("incoming face word carries a neighbor");

	// an index outside the box puts every face on the boundary
	a_range_boundary: assert property (@(posedge clk) disable iff (!arst_n)
		faces.valid && faces.range_error |-> faces.crosses_cellset)
		else $error("out of range cell with an interior face");

endmodule
`default_nettype wire
